// ===== rtl/ctpq_pkg.sv =====
package ctpq_pkg;

   localparam int KEY_W     = 16;
   localparam int PAYLOAD_W = 64;
   localparam int ID_W      = 11;
   localparam int LEN_W     = 4;
   localparam int RANK_W    = 12;
   localparam logic [LEN_W-1:0] MAX_LEN = 4'd8;

   // Request kinds carried in tuser.
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_POP    = 1'b1;

   // Command broadcast from the queue control to every cell.
   typedef struct packed {
      logic                 insert_en;
      logic                 pop_en;
      logic [KEY_W-1:0]     new_key;
      logic [PAYLOAD_W-1:0] new_payload;
   } ctpq_ctrl_type;

   // Keeps only the bytes below the data length code.
   function automatic logic [PAYLOAD_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
      logic [PAYLOAD_W-1:0] mask;
      mask = '0;
      for (int b = 0; b < 8; b++) begin
         mask[8*b +: 8] = (len > LEN_W'(b)) ? 8'hFF : 8'h00;
      end
      return mask;
   endfunction

endpackage

// ===== rtl/ctpq_cell.sv =====
module ctpq_cell
   import ctpq_pkg::*;
(
   input  logic                 clock,
   input  ctpq_ctrl_type        ctrl,
   input  logic                 valid,
   input  logic                 left_valid,
   input  logic                 left_gt,
   input  logic [KEY_W-1:0]     left_key,
   input  logic [PAYLOAD_W-1:0] left_payload,
   input  logic [KEY_W-1:0]     right_key,
   input  logic [PAYLOAD_W-1:0] right_payload,
   output logic [KEY_W-1:0]     key,
   output logic [PAYLOAD_W-1:0] payload,
   output logic                 gt
);

   logic [KEY_W-1:0]     key_ff, key_in;
   logic [PAYLOAD_W-1:0] payload_ff, payload_in;

   // The stored frame ranks below the incoming one, so it must move back.
   assign gt = valid && (key_ff[KEY_W-1 -: RANK_W] > ctrl.new_key[KEY_W-1 -: RANK_W]);

   // A pop shifts toward the head; an insert shifts lower-ranked frames back.
   // The first free cell also takes the old tail when the tail moves back.
   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      priority if (ctrl.pop_en) begin
         key_in     = right_key;
         payload_in = right_payload;
      end else if (ctrl.insert_en && left_gt) begin
         key_in     = left_key;
         payload_in = left_payload;
      end else if (ctrl.insert_en && (gt || (!valid && left_valid))) begin
         key_in     = ctrl.new_key;
         payload_in = ctrl.new_payload;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   assign key     = key_ff;
   assign payload = payload_ff;

endmodule

// ===== rtl/can_tx_priority_queue_core.sv =====
// Latency: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle; the chain of cells shifts all entries
// in parallel, and the result register frees whenever its result is taken.
// Reset clears the entry count and the result valid flag; frame contents in
// the cells are undefined until written and are never read before that.
module can_tx_priority_queue_core
   import ctpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: frame_id[10:0], remote[11], length[15:12], payload[79:16].
   input  logic [79:0] req_tdata,
   // Fields from bit 0: action[0].
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: done_res[0], out_id[11:1], out_remote[12],
   // out_length[16:13], out_payload[80:17], fill_level[85:81], zero pad[87:86].
   output logic [87:0] rsp_tdata
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [87:0]          rsp_data_ff, rsp_data_in;
   logic                 accept;
   logic                 is_pop, is_full, is_empty, stored;
   logic [ID_W-1:0]      in_id;
   logic                 in_remote;
   logic [LEN_W-1:0]     in_len, sat_len;
   logic [PAYLOAD_W-1:0] in_payload;
   ctpq_ctrl_type        ctrl;

   logic [KEY_W-1:0]     key_w     [QUEUE_DEPTH];
   logic [PAYLOAD_W-1:0] payload_w [QUEUE_DEPTH];
   logic                 gt_w      [QUEUE_DEPTH];
   logic                 valid_w   [QUEUE_DEPTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Request decode and frame normalization.
   assign in_id      = req_tdata[10:0];
   assign in_remote  = req_tdata[11];
   assign in_len     = req_tdata[15:12];
   assign in_payload = req_tdata[79:16];
   assign sat_len    = (in_len > MAX_LEN) ? MAX_LEN : in_len;
   assign is_pop     = (req_tuser == ACT_POP);
   assign is_full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign is_empty   = (count_ff == '0);
   assign stored     = !is_full || gt_w[QUEUE_DEPTH-1];

   // Command to the cells.
   always_comb begin
      ctrl.insert_en   = accept && !is_pop && stored;
      ctrl.pop_en      = accept && is_pop && !is_empty;
      ctrl.new_key     = {in_id, in_remote, sat_len};
      ctrl.new_payload = in_remote ? '0 : (in_payload & byte_mask(sat_len));
   end

   // Row of cells, head at index zero.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                 l_valid, l_gt;
      logic [KEY_W-1:0]     l_key, r_key;
      logic [PAYLOAD_W-1:0] l_payload, r_payload;

      assign valid_w[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign l_valid   = 1'b1;
         assign l_gt      = 1'b0;
         assign l_key     = ctrl.new_key;
         assign l_payload = ctrl.new_payload;
      end else begin : g_body
         assign l_valid   = valid_w[i-1];
         assign l_gt      = gt_w[i-1];
         assign l_key     = key_w[i-1];
         assign l_payload = payload_w[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign r_key     = key_w[i];
         assign r_payload = payload_w[i];
      end else begin : g_inner
         assign r_key     = key_w[i+1];
         assign r_payload = payload_w[i+1];
      end

      ctpq_cell u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .valid         (valid_w[i]),
         .left_valid    (l_valid),
         .left_gt       (l_gt),
         .left_key      (l_key),
         .left_payload  (l_payload),
         .right_key     (r_key),
         .right_payload (r_payload),
         .key           (key_w[i]),
         .payload       (payload_w[i]),
         .gt            (gt_w[i])
      );
   end

   // Entry count and result formation.
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         if (!is_pop) begin
            if (stored && !is_full) begin
               count_in = count_ff + CNT_W'(1);
            end
            rsp_data_in[0]     = stored;
            rsp_data_in[85:81] = 5'(count_in);
         end else if (!is_empty) begin
            count_in           = count_ff - CNT_W'(1);
            rsp_data_in[0]     = 1'b1;
            rsp_data_in[11:1]  = key_w[0][15:5];
            rsp_data_in[12]    = key_w[0][4];
            rsp_data_in[16:13] = key_w[0][3:0];
            rsp_data_in[80:17] = payload_w[0];
            rsp_data_in[85:81] = 5'(count_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The count never exceeds the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count beyond queue depth");

   // A pop of a non-empty queue removes exactly one entry.
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (accept && is_pop && !is_empty) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("pop did not remove one entry");

   // An insert into a queue with room always grows it by one.
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_pop && !is_full) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert with room did not store the frame");

   // Every accepted request leaves a result waiting.
   a_result_ready: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted request produced no result");

endmodule
